// File: sv/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and helpers for the HSV to RGB converter
// Beat payloads, the sector code and the front-end classification function.
// ----------------------------------------------------------------------------
package hsv_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] SECTOR_WIDTH  = 8'd43;
   localparam logic [7:0] FULL_SCALE    = 8'd254;
   // ceil(2^24 / 254); exact floor division for every product below 255 * 255
   localparam logic [16:0] RECIP_254    = 17'd66053;
   localparam int unsigned RECIP_SHIFT  = 24;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef enum logic [2:0] {
      SECT_RED_YELLOW   = 3'd0,
      SECT_YELLOW_GREEN = 3'd1,
      SECT_GREEN_CYAN   = 3'd2,
      SECT_CYAN_BLUE    = 3'd3,
      SECT_BLUE_MAGENTA = 3'd4,
      SECT_MAGENTA_RED  = 3'd5
   } sector_type;

   // work item handed from the front end to the back end
   typedef struct packed {
      logic       grey;
      sector_type sector;
      logic [7:0] frac;
      logic [7:0] sat;
      logic [7:0] val;
   } task_type;

   function automatic task_type classify(req_type req);
      task_type   tsk;
      logic [7:0] base;
      logic [7:0] offset;
      begin
         tsk.grey = (req.saturation == 8'd0);
         tsk.sat  = (req.saturation > FULL_SCALE) ? FULL_SCALE : req.saturation;
         tsk.val  = req.brightness;
         // compares against sector bounds; the top sector absorbs the tail
         if (req.hue >= 8'(SECTOR_WIDTH * 5)) begin
            tsk.sector = SECT_MAGENTA_RED;
            base       = 8'(SECTOR_WIDTH * 5);
         end else if (req.hue >= 8'(SECTOR_WIDTH * 4)) begin
            tsk.sector = SECT_BLUE_MAGENTA;
            base       = 8'(SECTOR_WIDTH * 4);
         end else if (req.hue >= 8'(SECTOR_WIDTH * 3)) begin
            tsk.sector = SECT_CYAN_BLUE;
            base       = 8'(SECTOR_WIDTH * 3);
         end else if (req.hue >= 8'(SECTOR_WIDTH * 2)) begin
            tsk.sector = SECT_GREEN_CYAN;
            base       = 8'(SECTOR_WIDTH * 2);
         end else if (req.hue >= SECTOR_WIDTH) begin
            tsk.sector = SECT_YELLOW_GREEN;
            base       = SECTOR_WIDTH;
         end else begin
            tsk.sector = SECT_RED_YELLOW;
            base       = 8'd0;
         end
         offset   = req.hue - base;
         // offset is at most 42, so times 6 fits in 8 bits
         tsk.frac = {offset[5:0], 2'b00} + {offset[6:0], 1'b0};
         return tsk;
      end
   endfunction

endpackage

// File: sv/hsv_front.sv
// ----------------------------------------------------------------------------
// hsv_front: input classification
// Takes request beats, finds sector, fraction and clamped saturation, and
// pushes the resulting work item into the queue.
// ----------------------------------------------------------------------------
module hsv_front
   import hsv_pkg::*;
(
   input  logic     req_push,
   input  req_type  req_data,
   input  logic     queue_full,
   output logic     queue_push,
   output task_type queue_data
);

   assign queue_push = req_push & ~queue_full;
   assign queue_data = classify(req_data);

endmodule

// File: sv/hsv_queue.sv
// ----------------------------------------------------------------------------
// hsv_queue: work item queue
// Small circular buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module hsv_queue
   import hsv_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_data,
   output logic     full,
   input  logic     pop,
   output task_type pop_data,
   output logic     empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   task_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/hsv_back.sv
// ----------------------------------------------------------------------------
// hsv_back: color arithmetic pipeline
// Three stages: saturation scaling, brightness products, division by 254
// with channel placement into the result register.
// ----------------------------------------------------------------------------
module hsv_back
   import hsv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     queue_empty,
   input  task_type queue_data,
   output logic     queue_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   typedef struct packed {
      logic       grey;
      sector_type sector;
      logic [7:0] p_term;
      logic [15:0] sat_frac;
      logic [15:0] sat_rest;
      logic [7:0] val;
   } stage1_type;

   typedef struct packed {
      logic        grey;
      sector_type  sector;
      logic [15:0] p_prod;
      logic [15:0] q_prod;
      logic [15:0] t_prod;
      logic [7:0]  val;
   } stage2_type;

   logic       advance;
   logic       s1_valid_ff, s1_valid_in;
   logic       s2_valid_ff, s2_valid_in;
   logic       out_valid_ff, out_valid_in;
   stage1_type s1_ff, s1_in;
   stage2_type s2_ff, s2_in;
   rsp_type    out_ff, out_in;

   logic [8:0]  q_fac, t_fac;
   logic [32:0] p_div, q_div, t_div;
   logic [7:0]  p_val, q_val, t_val;

   // whole pipeline moves together; it holds only while the result waits
   assign advance      = ~out_valid_ff | rsp_pop;
   assign queue_pop    = advance & ~queue_empty;
   assign s1_valid_in  = ~queue_empty;
   assign s2_valid_in  = s1_valid_ff;
   assign out_valid_in = s2_valid_ff;
   assign rsp_empty    = ~out_valid_ff;
   assign rsp_data     = out_ff;

   always_comb begin
      s1_in.grey     = queue_data.grey;
      s1_in.sector   = queue_data.sector;
      s1_in.p_term   = FULL_SCALE - queue_data.sat;
      s1_in.sat_frac = queue_data.sat * queue_data.frac;
      s1_in.sat_rest = queue_data.sat * (FULL_SCALE - queue_data.frac);
      s1_in.val      = queue_data.val;
   end

   always_comb begin
      q_fac         = {1'b0, FULL_SCALE} - {1'b0, s1_ff.sat_frac[15:8]};
      t_fac         = {1'b0, FULL_SCALE} - {1'b0, s1_ff.sat_rest[15:8]};
      s2_in.grey    = s1_ff.grey;
      s2_in.sector  = s1_ff.sector;
      s2_in.p_prod  = s1_ff.val * s1_ff.p_term;
      s2_in.q_prod  = s1_ff.val * q_fac[7:0];
      s2_in.t_prod  = s1_ff.val * t_fac[7:0];
      s2_in.val     = s1_ff.val;
   end

   always_comb begin
      p_div = s2_ff.p_prod * RECIP_254;
      q_div = s2_ff.q_prod * RECIP_254;
      t_div = s2_ff.t_prod * RECIP_254;
      p_val = p_div[RECIP_SHIFT +: 8];
      q_val = q_div[RECIP_SHIFT +: 8];
      t_val = t_div[RECIP_SHIFT +: 8];
      case (s2_ff.sector)
         SECT_RED_YELLOW: begin
            out_in = '{red: s2_ff.val, green: t_val, blue: p_val};
         end
         SECT_YELLOW_GREEN: begin
            out_in = '{red: q_val, green: s2_ff.val, blue: p_val};
         end
         SECT_GREEN_CYAN: begin
            out_in = '{red: p_val, green: s2_ff.val, blue: t_val};
         end
         SECT_CYAN_BLUE: begin
            out_in = '{red: p_val, green: q_val, blue: s2_ff.val};
         end
         SECT_BLUE_MAGENTA: begin
            out_in = '{red: t_val, green: p_val, blue: s2_ff.val};
         end
         default: begin
            out_in = '{red: s2_ff.val, green: p_val, blue: q_val};
         end
      endcase
      if (s2_ff.grey) begin
         out_in = '{red: s2_ff.val, green: s2_ff.val, blue: s2_ff.val};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         out_ff <= out_in;
      end
   end

endmodule

// File: sv/hsv_to_rgb_convert.sv
// An accepted beat passes through the queue entry, s1, s2 and the result register before it shows on the result ports.
// Throughput: one beat per cycle while the result side does not stall, set by the three-stage multiply pipeline.
// The work queue absorbs QUEUE_DEPTH beats while the result side stalls.
// Reset clears the queue pointers and the pipeline valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert: integer HSV to RGB converter
// Front end classifies each beat, a queue decouples it from the arithmetic
// back end, which places v, p, q and t terms on the red, green and blue channels.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert
   import hsv_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic     queue_push, queue_pop, queue_empty;
   task_type queue_in, queue_out;

   hsv_front u_front (
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (req_full),
      .queue_push (queue_push),
      .queue_data (queue_in)
   );

   hsv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_in),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_data  (queue_out),
      .empty     (queue_empty)
   );

   hsv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (queue_out),
      .queue_pop   (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule
